FILE: hdl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Types and constants shared by the record sort controller, datapath and top.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int KEY_FIELD_W = 24;
  localparam int PAYLOAD_W   = 16;
  localparam int POS_W       = 6;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] key;
    logic [PAYLOAD_W-1:0]   payload;
    logic                   last_item;
  } in_t;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] key_res;
    logic [PAYLOAD_W-1:0]   payload_res;
    logic [POS_W-1:0]       position;
    logic                   overflow;
    logic                   last_result;
  } out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_A,
    ST_LD_A,
    ST_CMP,
    ST_PUT,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  // datapath commands, at most one memory write per cycle
  typedef struct packed {
    logic load;
    logic sort_start;
    logic rd_a;
    logic rd_prev;
    logic shift;
    logic put;
    logic emit_rd;
    logic emit_out;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic a_done;
    logic b_one;
    logic key_lt;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

FILE: hdl/rsd_ctrl.sv
// ----------------------------------------------------------------------------
// rsd_ctrl
// Sequencer for load, stable insertion sort and emission of the record set.
// ----------------------------------------------------------------------------
module rsd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  rsd_pkg::sts_t sts,
  output rsd_pkg::cmd_t cmd
);

  rsd_pkg::state_t state_r;
  rsd_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsd_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsd_pkg::ST_LOAD: begin
        if (in_valid && in_last) begin
          state_nxt = rsd_pkg::ST_RD_A;
        end
      end
      rsd_pkg::ST_RD_A: begin
        state_nxt = sts.a_done ? rsd_pkg::ST_EMIT_RD : rsd_pkg::ST_LD_A;
      end
      rsd_pkg::ST_LD_A: begin
        state_nxt = rsd_pkg::ST_CMP;
      end
      rsd_pkg::ST_CMP: begin
        if (sts.key_lt) begin
          state_nxt = sts.b_one ? rsd_pkg::ST_PUT : rsd_pkg::ST_CMP;
        end else begin
          state_nxt = rsd_pkg::ST_RD_A;
        end
      end
      rsd_pkg::ST_PUT: begin
        state_nxt = rsd_pkg::ST_RD_A;
      end
      rsd_pkg::ST_EMIT_RD: begin
        state_nxt = rsd_pkg::ST_EMIT_OUT;
      end
      rsd_pkg::ST_EMIT_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.emit_last ? rsd_pkg::ST_LOAD : rsd_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = rsd_pkg::ST_LOAD;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      rsd_pkg::ST_LOAD: begin
        in_ready       = 1'b1;
        cmd.load       = in_valid;
        cmd.sort_start = in_valid && in_last;
      end
      rsd_pkg::ST_RD_A: begin
        cmd.rd_a = !sts.a_done;
      end
      rsd_pkg::ST_LD_A: begin
        cmd.rd_prev = 1'b1;
      end
      rsd_pkg::ST_CMP: begin
        // shift the smaller neighbour up, or drop the held record in place
        cmd.shift = sts.key_lt;
        cmd.put   = !sts.key_lt;
      end
      rsd_pkg::ST_PUT: begin
        cmd.put = 1'b1;
      end
      rsd_pkg::ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
      end
      rsd_pkg::ST_EMIT_OUT: begin
        cmd.emit_out = sts.out_free;
        cmd.clear    = sts.out_free && sts.emit_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: hdl/rsd_dp.sv
// ----------------------------------------------------------------------------
// rsd_dp
// Record store, sort indices, compare and the registered result beat.
// ----------------------------------------------------------------------------
module rsd_dp #(
  parameter int MAX_RECORDS = 64,
  parameter int KEY_BITS    = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rsd_pkg::in_t  in_data,
  input  rsd_pkg::cmd_t cmd,
  output rsd_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output rsd_pkg::out_t out_data
);

  localparam int KW = (KEY_BITS < rsd_pkg::KEY_FIELD_W) ? KEY_BITS : rsd_pkg::KEY_FIELD_W;
  localparam int MW = KW + rsd_pkg::PAYLOAD_W;
  localparam int IW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  logic [MW-1:0] mem_r [MAX_RECORDS];
  logic [MW-1:0] rd_data_r;
  logic [MW-1:0] hold_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] a_r;
  logic [IW-1:0] b_r;
  logic [IW-1:0] e_r;
  logic          drop_r;
  logic          out_valid_r;
  rsd_pkg::out_t out_data_r;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [MW-1:0] wr_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          room;
  logic [KW-1:0] rd_key;
  logic [KW-1:0] hold_key;

  assign room     = cnt_r < CW'(MAX_RECORDS);
  assign rd_key   = rd_data_r[MW-1 -: KW];
  assign hold_key = hold_r[MW-1 -: KW];

  // single write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = b_r;
    wr_data = hold_r;
    if (cmd.load) begin
      wr_en   = room;
      wr_addr = cnt_r[IW-1:0];
      wr_data = {in_data.key[KW-1:0], in_data.payload};
    end else if (cmd.shift) begin
      wr_en   = 1'b1;
      wr_data = rd_data_r;
    end else if (cmd.put) begin
      wr_en   = 1'b1;
    end
  end

  // single read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = e_r;
    if (cmd.rd_a) begin
      rd_en   = 1'b1;
      rd_addr = a_r[IW-1:0];
    end else if (cmd.rd_prev) begin
      rd_en   = 1'b1;
      rd_addr = b_r - IW'(1);
    end else if (cmd.shift) begin
      // next neighbour down, none left once b reaches one
      rd_en   = (b_r != IW'(1));
      rd_addr = b_r - IW'(2);
    end else if (cmd.emit_rd) begin
      rd_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_prev) begin
      hold_r <= rd_data_r;
    end
    if (cmd.rd_a) begin
      b_r <= a_r[IW-1:0];
    end else if (cmd.shift) begin
      b_r <= b_r - IW'(1);
    end
    if (cmd.sort_start) begin
      a_r <= CW'(1);
    end else if (cmd.put) begin
      a_r <= a_r + CW'(1);
    end
    if (cmd.sort_start) begin
      e_r <= '0;
    end else if (cmd.emit_out) begin
      e_r <= e_r + IW'(1);
    end
    if (cmd.emit_out) begin
      out_data_r.key_res     <= rsd_pkg::KEY_FIELD_W'(rd_key);
      out_data_r.payload_res <= rd_data_r[rsd_pkg::PAYLOAD_W-1:0];
      out_data_r.position    <= rsd_pkg::POS_W'(e_r);
      out_data_r.overflow    <= drop_r;
      out_data_r.last_result <= sts.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        cnt_r  <= '0;
        drop_r <= 1'b0;
      end else if (cmd.load) begin
        if (room) begin
          cnt_r <= cnt_r + CW'(1);
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (cmd.emit_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.a_done    = a_r >= cnt_r;
  assign sts.b_one     = b_r == IW'(1);
  assign sts.key_lt    = rd_key < hold_key;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.emit_last = (CW'(e_r) + CW'(1)) == cnt_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/record_sort_by_key_desc_core.sv
// ----------------------------------------------------------------------------
// record_sort_by_key_desc_core
// Stable descending sort of a record set, loaded one record per beat.
// Load: one record per cycle; the beat flagged last closes the set.
// Sort: insertion sort over one single-port-read store; each record after the
//   first is read and held, every smaller record below it is shifted up, then
//   the held record is put in place, at most n*(n-1)/2 shifts for n records.
// Emit: each result beat is a store read, then the output register, which waits while the output stalls.
// Synchronous active-low reset clears control state; the store is not cleared.
// ----------------------------------------------------------------------------
module record_sort_by_key_desc_core #(
  parameter int MAX_RECORDS = 64,
  parameter int KEY_BITS    = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rsd_pkg::out_t out_data
);

  rsd_pkg::cmd_t cmd;
  rsd_pkg::sts_t sts;

  rsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_item),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rsd_dp #(
    .MAX_RECORDS (MAX_RECORDS),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: bench/rsd_sort_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsd_sort_checker
// Watches the record and result channels and keeps its own copy of the store.
// When a set closes it ranks the held records by key, largest first, with
// equal keys kept in load order. Each result beat is then checked field by
// field against the oldest predicted record.
// ----------------------------------------------------------------------------
module rsd_sort_checker #(
  parameter int MAX_RECORDS = 64,
  parameter int KEY_BITS    = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  rsd_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  rsd_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);

  localparam logic [rsd_pkg::KEY_FIELD_W-1:0] KEY_MASK =
    rsd_pkg::KEY_FIELD_W'((64'd1 << KEY_BITS) - 1);

  logic [rsd_pkg::KEY_FIELD_W-1:0] held_key [MAX_RECORDS];
  logic [rsd_pkg::PAYLOAD_W-1:0]   held_pay [MAX_RECORDS];
  int                              held_n;
  logic                            dropped;
  rsd_pkg::out_t                   sorted_q [$];
  int                              errs;

  initial begin
    held_n  = 0;
    dropped = 1'b0;
    errs    = 0;
  end

  // rank of a record: all strictly larger keys, plus equal keys loaded earlier
  task automatic close_set();
    rsd_pkg::out_t ranked [MAX_RECORDS];
    int            slot;
    for (int i = 0; i < held_n; i++) begin
      slot = 0;
      for (int j = 0; j < held_n; j++) begin
        if (held_key[j] > held_key[i] || (j < i && held_key[j] == held_key[i]))
          slot++;
      end
      ranked[slot] = {held_key[i], held_pay[i], slot[rsd_pkg::POS_W-1:0], dropped,
                      (slot == held_n - 1)};
    end
    for (int r = 0; r < held_n; r++)
      sorted_q.push_back(ranked[r]);
    held_n  = 0;
    dropped = 1'b0;
  endtask

  task automatic take_record(input rsd_pkg::in_t rec);
    if (held_n < MAX_RECORDS) begin
      held_key[held_n] = rec.key & KEY_MASK;
      held_pay[held_n] = rec.payload;
      held_n++;
    end else begin
      // store full: the record is lost, last or not
      dropped = 1'b1;
    end
    if (rec.last_item)
      close_set();
  endtask

  task automatic check_result(input rsd_pkg::out_t got);
    rsd_pkg::out_t want;
    if (sorted_q.size() == 0) begin
      $error("unexpected result beat: key_res %0h position %0d", got.key_res, got.position);
      errs++;
    end else begin
      want = sorted_q.pop_front();
      if (got.key_res !== want.key_res) begin
        $error("key_res: expected %0h, got %0h", want.key_res, got.key_res);
        errs++;
      end
      if (got.payload_res !== want.payload_res) begin
        $error("payload_res: expected %0h, got %0h", want.payload_res, got.payload_res);
        errs++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        errs++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
        errs++;
      end
      if (got.last_result !== want.last_result) begin
        $error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        check_result(out_data);
      if (in_valid && in_ready)
        take_record(in_data);
    end
    fail_count <= errs;
    pending    <= sorted_q.size();
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives record sets into the descending sort core and gives the verdict.
// A short directed run covers single records, ties, extremes and presorted
// orders; random sets follow, one of them overrunning the store. Both
// channels idle at random apart from a stretch of back-to-back beats.
// ----------------------------------------------------------------------------
module tb_top;

  typedef enum int {
    KEYS_WIDE,
    KEYS_TIED,
    KEYS_EXTREME
  } key_mix_t;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  rsd_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  rsd_pkg::out_t out_data;
  logic          steady    = 1'b0;
  int            fail_count;
  int            pending;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  record_sort_by_key_desc_core dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data
  );

  rsd_sort_checker u_check (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data,
    .fail_count,
    .pending
  );

  always @(posedge clk)
    out_ready <= steady || ($urandom_range(0, 99) >= 14);

  function automatic logic [rsd_pkg::KEY_FIELD_W-1:0] random_key(input key_mix_t mix);
    case (mix)
      KEYS_TIED: return rsd_pkg::KEY_FIELD_W'($urandom_range(0, 3));
      KEYS_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return 24'h800000;
          default: return rsd_pkg::KEY_FIELD_W'($urandom());
        endcase
      end
      default: return rsd_pkg::KEY_FIELD_W'($urandom());
    endcase
  endfunction

  task automatic send_record(input logic [rsd_pkg::KEY_FIELD_W-1:0] k,
                             input logic [rsd_pkg::PAYLOAD_W-1:0] p,
                             input logic lst);
    while (!steady && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {k, p, lst};
    do
      @(posedge clk);
    while (!in_ready);
  endtask

  task automatic send_set(input int n, input key_mix_t mix);
    for (int i = 0; i < n; i++)
      send_record(random_key(mix), rsd_pkg::PAYLOAD_W'($urandom()), (i == n - 1));
  endtask

  initial begin
    int sent;
    int set_idx;
    int set_len;
    int guard;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-record sets at both extremes
    send_record('1, '1, 1'b1);
    send_record('0, '0, 1'b1);

    // ties between extremes must keep load order
    send_record(24'd5, 16'h0001, 1'b0);
    send_record('1, 16'h0002, 1'b0);
    send_record(24'd5, 16'h0003, 1'b0);
    send_record('0, 16'h0004, 1'b0);
    send_record(24'd5, 16'h0005, 1'b0);
    send_record('1, 16'h0006, 1'b0);
    send_record('0, 16'h0007, 1'b1);

    // ascending load is the worst case for shifting, descending needs none
    for (int i = 1; i <= 5; i++)
      send_record(rsd_pkg::KEY_FIELD_W'(i), rsd_pkg::PAYLOAD_W'(16'h1000 + i), (i == 5));
    for (int i = 4; i >= 1; i--)
      send_record(rsd_pkg::KEY_FIELD_W'(i * 1000), rsd_pkg::PAYLOAD_W'(16'h2000 + i),
                  (i == 1));

    // the directed beats above count towards the total
    sent    = 18;
    set_idx = 0;
    while (sent < 110) begin
      // one set overruns the store, the closing beat is dropped with it
      if (set_idx == 2)
        set_len = $urandom_range(65, 68);
      else
        set_len = $urandom_range(1, 8);
      steady <= (set_idx >= 1 && set_idx <= 2);
      send_set(set_len, key_mix_t'($urandom_range(0, 2)));
      sent += set_len;
      set_idx++;
    end
    steady   <= 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
